// ===== hdl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types, codes and helpers of the meeting-cost priority table.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int unsigned MAX_LOCATIONS_DEF = 1024;
	localparam int unsigned MAX_SNAPSHOTS_DEF = 256;

	localparam int unsigned LOC_W  = 16;
	localparam int unsigned DIST_W = 15;
	localparam int unsigned TIME_W = 16;
	localparam int unsigned COST_W = 18;
	localparam int unsigned AGT_W  = 8;
	localparam int unsigned SIDX_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COST_MODE  = 2'd0,
		REG_TASK_START = 2'd1,
		REG_AGENT_A    = 2'd2,
		REG_AGENT_B    = 2'd3
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_MEETING = 1'b0,
		ST_EMPTY   = 1'b1
	} status_t;

	// one meeting: location, time, cost
	typedef struct packed {
		logic [LOC_W-1:0]  loc;
		logic [TIME_W-1:0] tm;
		logic [COST_W-1:0] cost;
	} meet_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PUSH_UP,
		S_PUSH_CMP,
		S_PUSH_END,
		S_POP_TOP,
		S_POP_LAST,
		S_POP_GET,
		S_SIFT,
		S_SIFT_C1,
		S_SIFT_C2,
		S_SIFT_CMP,
		S_POP_END,
		S_REC_RD,
		S_REC_WR,
		S_QCHK,
		S_ANS_RD,
		S_ANS
	} state_t;

endpackage

// ===== hdl/mct_if.sv =====
// ----------------------------------------------------------------------------
// mct_in_if / mct_out_if
// Valid/ready channels of the meeting-cost priority table.
// ----------------------------------------------------------------------------
interface mct_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [15:0]               location;
	logic [14:0]               dist_from_task_start;
	logic [14:0]               dist_from_agent_b;
	logic [14:0]               dist_to_goal;
	logic [7:0]                snapshot_index;

	modport source (output valid, kind, location, dist_from_task_start,
		dist_from_agent_b, dist_to_goal, snapshot_index, input ready);
	modport sink (input valid, kind, location, dist_from_task_start,
		dist_from_agent_b, dist_to_goal, snapshot_index, output ready);
endinterface

interface mct_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [15:0] meet_loc;
	logic [15:0] meet_tm;
	logic [7:0]  agent_a;
	logic [7:0]  agent_b;
	logic [17:0] meeting_cost;

	modport source (output valid, status, meet_loc, meet_tm,
		agent_a, agent_b, meeting_cost, input ready);
	modport sink (input valid, status, meet_loc, meet_tm,
		agent_a, agent_b, meeting_cost, output ready);
endinterface

// ===== hdl/meeting_cost_priority_table.sv =====
// ----------------------------------------------------------------------------
// meeting_cost_priority_table
// Min-cost binary heap of candidate meetings with a snapshot history.
// ----------------------------------------------------------------------------
// A load beat runs a sift-up that walks the heap memory, one parent read
// and compare per level over its single read port. A clear or ignored
// load leaves the table idle and ready. A query on recorded snapshots
// reads the snapshot and waits for the output; each advance it replays
// runs a sift-down (reading up to two children per level) and then the
// sift-up, and a query that must build new snapshots repeats this for
// each one. Input ready is low while any of this runs.
// There is no clearing pass after reset.
module meeting_cost_priority_table #(
	parameter int unsigned MAX_LOCATIONS = mct_pkg::MAX_LOCATIONS_DEF,
	parameter int unsigned MAX_SNAPSHOTS = mct_pkg::MAX_SNAPSHOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mct_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mct_pkg::CFG_DATA_W-1:0] cfg_data,
	mct_in_if.sink                        in_ch,
	mct_out_if.source                     out_ch
);
	import mct_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_LOCATIONS);
	localparam int unsigned CNT_W = $clog2(MAX_LOCATIONS + 1);
	localparam int unsigned ORD_W = $clog2(MAX_LOCATIONS + MAX_SNAPSHOTS);
	localparam int unsigned SN_W  = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1;
	localparam int unsigned REC_W = $clog2(MAX_SNAPSHOTS + 1);
	localparam int unsigned CMP_W = (REC_W > SIDX_W) ? REC_W + 1 : SIDX_W + 1;
	localparam int unsigned CW    = IDX_W + 2;

	typedef struct packed {
		logic [ORD_W-1:0] order;
		meet_t            m;
	} hent_t;

	function automatic logic ahead(input hent_t a, input hent_t b);
		if (a.m.cost != b.m.cost)
			return a.m.cost < b.m.cost;
		return a.order < b.order;
	endfunction

	// configuration registers
	logic                cost_mode_q;
	logic [DIST_W-1:0]   task_start_q;
	logic [AGT_W-1:0]    agent_a_q;
	logic [AGT_W-1:0]    agent_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_mode_q  <= 1'b0;
			task_start_q <= '0;
			agent_a_q    <= '0;
			agent_b_q    <= AGT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_COST_MODE:  cost_mode_q  <= cfg_data[0];
				REG_TASK_START: task_start_q <= cfg_data;
				REG_AGENT_A:    agent_a_q    <= cfg_data[AGT_W-1:0];
				REG_AGENT_B:    agent_b_q    <= cfg_data[AGT_W-1:0];
				default: ;
			endcase
		end
	end

	// heap and snapshot memories
	hent_t heap_mem [MAX_LOCATIONS];
	meet_t snap_mem [MAX_SNAPSHOTS];

	logic             h_re, h_we;
	logic [IDX_W-1:0] h_ra, h_wa;
	hent_t            h_wd, h_rd_q;
	logic             s_re, s_we;
	logic [SN_W-1:0]  s_ra, s_wa;
	meet_t            s_wd, s_rd_q;

	always_ff @(posedge clk) begin
		if (h_we)
			heap_mem[h_wa] <= h_wd;
		if (h_re)
			h_rd_q <= heap_mem[h_ra];
	end

	always_ff @(posedge clk) begin
		if (s_we)
			snap_mem[s_wa] <= s_wd;
		if (s_re)
			s_rd_q <= snap_mem[s_ra];
	end

	// control and datapath state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [ORD_W-1:0] ord_q;
	logic [REC_W-1:0] rec_q;
	logic [SN_W-1:0]  k_q;
	logic             qry_q;
	logic             empty_q;
	logic [IDX_W-1:0] i_q;
	hent_t            e_q, top_q, last_q, ch_q;
	logic [IDX_W-1:0] ch_idx_q;

	logic             out_valid_q;
	meet_t            out_m_q;
	logic             out_status_q;
	logic [AGT_W-1:0] out_a_q, out_b_q;

	// load entry math
	logic [TIME_W-1:0] ld_a, ld_b, ld_time;
	logic [COST_W-1:0] ld_cost;
	hent_t             ld_ent;

	always_comb begin
		ld_a    = TIME_W'(in_ch.dist_from_task_start) + TIME_W'(task_start_q);
		ld_b    = TIME_W'(in_ch.dist_from_agent_b);
		ld_time = (ld_a > ld_b) ? ld_a : ld_b;
		ld_cost = (cost_mode_q ? COST_W'(ld_time) : COST_W'({ld_time, 1'b0}))
			+ COST_W'(in_ch.dist_to_goal);
		ld_ent.order = ord_q;
		ld_ent.m.loc = in_ch.location;
		ld_ent.m.tm  = ld_time;
		ld_ent.m.cost = ld_cost;
	end

	// reinsert entry after a pop
	logic [COST_W:0] adv_sum;
	hent_t           adv_ent;

	always_comb begin
		adv_sum = {1'b0, top_q.m.cost} + (cost_mode_q ? (COST_W+1)'(1) : (COST_W+1)'(2));
		adv_ent.order = ord_q;
		adv_ent.m.loc = top_q.m.loc;
		adv_ent.m.tm  = (top_q.m.tm == TIME_MAX) ? TIME_MAX : top_q.m.tm + 1'b1;
		adv_ent.m.cost = (adv_sum > {1'b0, COST_MAX}) ? COST_MAX : adv_sum[COST_W-1:0];
	end

	// heap index helpers
	logic [CW-1:0]    c_w, c1_w, cnt_w;
	logic [IDX_W-1:0] par;
	logic             accept;
	logic             out_free;
	logic [CMP_W-1:0] k_clamp;
	logic             rec_le_k;

	always_comb begin
		c_w   = {1'b0, i_q, 1'b1};
		c1_w  = c_w + 1'b1;
		cnt_w = CW'(cnt_q);
		par   = IDX_W'((i_q - 1'b1) >> 1);
		accept = in_ch.valid && in_ch.ready;
		out_free = !out_valid_q || out_ch.ready;
		k_clamp = (CMP_W'(in_ch.snapshot_index) > CMP_W'(MAX_SNAPSHOTS - 1))
			? CMP_W'(MAX_SNAPSHOTS - 1) : CMP_W'(in_ch.snapshot_index);
		rec_le_k = CMP_W'(rec_q) <= CMP_W'(k_q);
	end

	assign in_ch.ready = (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		h_re = 1'b0;
		h_ra = '0;
		h_we = 1'b0;
		h_wa = i_q;
		h_wd = e_q;
		s_re = 1'b0;
		s_ra = k_q;
		s_we = 1'b0;
		s_wa = SN_W'(rec_q);
		s_wd = h_rd_q.m;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind_t'(in_ch.kind))
						KIND_LOAD:
							if (rec_q == '0 && cnt_q != CNT_W'(MAX_LOCATIONS))
								state_d = S_PUSH_UP;
						KIND_QUERY:
							if (cnt_q == '0)
								state_d = S_ANS;
							else if (rec_q == '0)
								state_d = S_REC_RD;
							else
								state_d = S_QCHK;
						default: ;
					endcase
				end
			end
			S_PUSH_UP: begin
				if (i_q == '0) begin
					state_d = S_PUSH_END;
				end else begin
					h_re = 1'b1;
					h_ra = par;
					state_d = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				if (ahead(e_q, h_rd_q)) begin
					h_we = 1'b1;
					h_wd = h_rd_q;
					state_d = S_PUSH_UP;
				end else begin
					state_d = S_PUSH_END;
				end
			end
			S_PUSH_END: begin
				h_we = 1'b1;
				state_d = qry_q ? S_REC_RD : S_IDLE;
			end
			S_POP_TOP: begin
				h_re = 1'b1;
				h_ra = '0;
				state_d = S_POP_LAST;
			end
			// count is already one down here, so it points at the last entry
			S_POP_LAST: begin
				h_re = 1'b1;
				h_ra = IDX_W'(cnt_q);
				state_d = S_POP_GET;
			end
			S_POP_GET: state_d = S_SIFT;
			S_SIFT: begin
				if (c_w >= cnt_w) begin
					state_d = S_POP_END;
				end else begin
					h_re = 1'b1;
					h_ra = c_w[IDX_W-1:0];
					state_d = S_SIFT_C1;
				end
			end
			S_SIFT_C1: begin
				if (c1_w < cnt_w) begin
					h_re = 1'b1;
					h_ra = c1_w[IDX_W-1:0];
					state_d = S_SIFT_C2;
				end else begin
					state_d = S_SIFT_CMP;
				end
			end
			S_SIFT_C2: state_d = S_SIFT_CMP;
			S_SIFT_CMP: begin
				if (ahead(ch_q, last_q)) begin
					h_we = 1'b1;
					h_wd = ch_q;
					state_d = S_SIFT;
				end else begin
					state_d = S_POP_END;
				end
			end
			S_POP_END: begin
				h_we = (cnt_q != '0);
				h_wd = last_q;
				state_d = S_PUSH_UP;
			end
			S_REC_RD: begin
				h_re = 1'b1;
				h_ra = '0;
				state_d = S_REC_WR;
			end
			S_REC_WR: begin
				s_we = 1'b1;
				state_d = S_QCHK;
			end
			S_QCHK: state_d = rec_le_k ? S_POP_TOP : S_ANS_RD;
			S_ANS_RD: begin
				s_re = 1'b1;
				state_d = S_ANS;
			end
			S_ANS: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ord_q   <= '0;
			rec_q   <= '0;
			qry_q   <= 1'b0;
			empty_q <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind_t'(in_ch.kind))
							KIND_LOAD:
								if (rec_q == '0 && cnt_q != CNT_W'(MAX_LOCATIONS)) begin
									cnt_q <= cnt_q + 1'b1;
									ord_q <= ord_q + 1'b1;
									qry_q <= 1'b0;
								end
							KIND_QUERY: begin
								k_q     <= SN_W'(k_clamp);
								empty_q <= (cnt_q == '0);
								qry_q   <= 1'b1;
							end
							KIND_CLEAR: begin
								cnt_q <= '0;
								ord_q <= '0;
								rec_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_POP_TOP: cnt_q <= cnt_q - 1'b1;
				S_POP_END: begin
					cnt_q <= cnt_q + 1'b1;
					ord_q <= ord_q + 1'b1;
				end
				S_REC_WR: rec_q <= rec_q + 1'b1;
				default: ;
			endcase
		end
	end

	// heap walk registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				e_q <= ld_ent;
				i_q <= IDX_W'(cnt_q);
			end
			S_PUSH_CMP: if (ahead(e_q, h_rd_q)) i_q <= par;
			S_POP_LAST: top_q <= h_rd_q;
			S_POP_GET: begin
				last_q <= h_rd_q;
				i_q    <= '0;
			end
			S_SIFT_C1: begin
				ch_q     <= h_rd_q;
				ch_idx_q <= c_w[IDX_W-1:0];
			end
			S_SIFT_C2: begin
				if (ahead(h_rd_q, ch_q)) begin
					ch_q     <= h_rd_q;
					ch_idx_q <= c1_w[IDX_W-1:0];
				end
			end
			S_SIFT_CMP: if (ahead(ch_q, last_q)) i_q <= ch_idx_q;
			S_POP_END: begin
				e_q <= adv_ent;
				i_q <= IDX_W'(cnt_q);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_ANS && out_free)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ANS && out_free) begin
			out_status_q <= empty_q ? ST_EMPTY : ST_MEETING;
			out_m_q      <= empty_q ? '0 : s_rd_q;
			out_a_q      <= empty_q ? '0 : agent_a_q;
			out_b_q      <= empty_q ? '0 : agent_b_q;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.status           = out_status_q;
	assign out_ch.meet_loc         = out_m_q.loc;
	assign out_ch.meet_tm          = out_m_q.tm;
	assign out_ch.meeting_cost     = out_m_q.cost;
	assign out_ch.agent_a          = out_a_q;
	assign out_ch.agent_b          = out_b_q;

endmodule

// ===== hdl/mct_checker.sv =====
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks of the meeting-cost priority table, bound to the top.
// ----------------------------------------------------------------------------
module mct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_status,
	input logic [15:0] out_loc,
	input logic [17:0] out_cost
);
	import mct_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_loc) && $stable(out_cost))
		else $error("result beat changed while stalled");

	// an empty answer carries no meeting
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_EMPTY |-> out_loc == '0 && out_cost == '0)
		else $error("empty answer with nonzero fields");

	// a query always starts work
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
		else $error("ready after query beat");

	// a clear finishes at once
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == KIND_CLEAR |=> in_ready)
		else $error("busy after clear beat");

endmodule

bind meeting_cost_priority_table mct_checker u_mct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_kind    (in_ch.kind),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status),
	.out_loc    (out_ch.meet_loc),
	.out_cost   (out_ch.meeting_cost)
);
